@@ sv/multi_priority_event_queue_top_assert.svh @@
// Assertion macros for the multi-priority event queue.
`ifndef MULTI_PRIORITY_EVENT_QUEUE_TOP_ASSERT_SVH
`define MULTI_PRIORITY_EVENT_QUEUE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// ante holds -> cons holds in the same cycle
`define MPEQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mpeq: same-cycle check failed");
// ante holds -> cons holds in the next cycle
`define MPEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mpeq: next-cycle check failed");
`else
`define MPEQ_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define MPEQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ sv/mpeq_pkg.sv @@
// Shared types and constants of the multi-priority event queue.
`default_nettype none
package mpeq_pkg;

  // fixed field widths
  localparam int PRIO_REQ_W = 8;
  localparam int ID_W       = 8;
  localparam int SIZE_W     = 8;
  localparam int DATA_W     = 64;
  localparam int STATUS_W   = 3;
  localparam int OUT_PRIO_W = 2;
  localparam int OUT_SIZE_W = 4;
  localparam int DEPTH_W    = 4;
  localparam int DROP_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int MODE_W     = 2;
  localparam int FALLBACK_W = 2;
  localparam int LIMIT_W    = 9;
  localparam int EPR_W      = 3;

  // request commands
  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_ROUND = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_QUEUED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HALTED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EVENT   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd5;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_PRIO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_LIMIT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PER_ROUND     = 2'd3;

  // overflow modes (code 3 behaves as reject)
  localparam logic [MODE_W-1:0] MODE_REJECT      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DROP_OLDEST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HALT        = 2'd2;

  // config reset values
  localparam logic [MODE_W-1:0]     RST_MODE      = 2'd0;
  localparam logic [FALLBACK_W-1:0] RST_FALLBACK  = 2'd3;
  localparam logic [LIMIT_W-1:0]    RST_LIMIT     = 9'd256;
  localparam logic [EPR_W-1:0]      RST_PER_ROUND = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic exec_single;
    logic round_start;
    logic issue;
    logic next_prio;
    logic round_end;
    logic emit_event;
    logic emit_empty;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_round;
    logic halted;
    logic out_free;
    logic can_pop;
    logic prio_final;
    logic issue_last;
  } ctrl_sts_t;

endpackage
`default_nettype wire

@@ sv/mpeq_ctrl.sv @@
// Sequencing state machine of the multi-priority event queue.
`default_nettype none
module mpeq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire mpeq_pkg::ctrl_sts_t  sts,
  output mpeq_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_EMIT,
    S_EMPTY
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_round && !sts.halted) begin
          cmd.round_start = 1'b1;
          state_next      = S_SCAN;
        end else if (sts.out_free) begin
          cmd.exec_single = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.can_pop) begin
          cmd.issue  = 1'b1;
          state_next = S_EMIT;
        end else if (sts.prio_final) begin
          // walked every priority without finding an event
          cmd.round_end = 1'b1;
          state_next    = S_EMPTY;
        end else begin
          cmd.next_prio = 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_event = 1'b1;
          state_next     = sts.issue_last ? S_IDLE : S_SCAN;
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.emit_empty = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_stall <= 1'b0;
    end else begin
      state    <= state_next;
      in_stall <= (state_next != S_IDLE);
    end
  end

endmodule
`default_nettype wire

@@ sv/mpeq_dp.sv @@
// Datapath of the multi-priority event queue: rings, event store, result register.
`default_nettype none
module mpeq_dp #(
  parameter int NUM_PRIORITIES = 4,
  parameter int QUEUE_DEPTH    = 16,
  parameter int PAYLOAD_BYTES  = 8,
  parameter int MAX_PER_ROUND  = 4
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  // configuration
  input  wire logic                                    cfg_write,
  input  wire logic [mpeq_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [mpeq_pkg::CFG_DATA_W-1:0]         cfg_data,
  // request fields
  input  wire logic                                    cmd_in,
  input  wire logic [mpeq_pkg::PRIO_REQ_W-1:0]         priority_req,
  input  wire logic [mpeq_pkg::ID_W-1:0]               type_id,
  input  wire logic [mpeq_pkg::SIZE_W-1:0]             event_size,
  input  wire logic [mpeq_pkg::DATA_W-1:0]             payload,
  // control
  input  wire mpeq_pkg::ctrl_cmd_t                     cmd,
  output mpeq_pkg::ctrl_sts_t                          sts,
  // result register
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic [mpeq_pkg::STATUS_W-1:0]                status,
  output logic [mpeq_pkg::OUT_PRIO_W-1:0]              out_priority,
  output logic [mpeq_pkg::ID_W-1:0]                    out_id,
  output logic [mpeq_pkg::OUT_SIZE_W-1:0]              out_len,
  output logic [mpeq_pkg::DATA_W-1:0]                  out_payload,
  output logic                                         last,
  output logic [mpeq_pkg::DEPTH_W-1:0]                 depth,
  output logic [mpeq_pkg::DROP_W-1:0]                  drop_count
);

  localparam int PW       = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
  localparam int PTRW     = $clog2(QUEUE_DEPTH);
  localparam int KW       = $clog2(MAX_PER_ROUND + 1);
  localparam int STORE_W  = PAYLOAD_BYTES * 8;
  localparam int MEM_AW   = PW + PTRW;
  localparam int MEM_SIZE = 1 << MEM_AW;
  localparam int DW       = mpeq_pkg::DATA_W;
  localparam int DROPW    = mpeq_pkg::DROP_W;
  localparam int OPW      = mpeq_pkg::OUT_PRIO_W;
  localparam int DEPW     = mpeq_pkg::DEPTH_W;
  localparam int OSW      = mpeq_pkg::OUT_SIZE_W;

  typedef struct packed {
    logic [mpeq_pkg::ID_W-1:0] id;
    logic [OSW-1:0]            size;
    logic [STORE_W-1:0]        data;
  } entry_t;

  function automatic logic [PTRW-1:0] ptr_inc(input logic [PTRW-1:0] p);
    return (p == PTRW'(QUEUE_DEPTH - 1)) ? '0 : p + PTRW'(1);
  endfunction

  // configuration registers
  logic [mpeq_pkg::MODE_W-1:0]     mode;
  logic [mpeq_pkg::FALLBACK_W-1:0] fallback;
  logic [mpeq_pkg::LIMIT_W-1:0]    type_limit;
  logic [mpeq_pkg::EPR_W-1:0]      per_round;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= mpeq_pkg::RST_MODE;
      fallback   <= mpeq_pkg::RST_FALLBACK;
      type_limit <= mpeq_pkg::RST_LIMIT;
      per_round  <= mpeq_pkg::RST_PER_ROUND;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mpeq_pkg::CFG_OVERFLOW_MODE: mode       <= cfg_data[mpeq_pkg::MODE_W-1:0];
        mpeq_pkg::CFG_FALLBACK_PRIO: fallback   <= cfg_data[mpeq_pkg::FALLBACK_W-1:0];
        mpeq_pkg::CFG_TYPE_LIMIT:    type_limit <= cfg_data[mpeq_pkg::LIMIT_W-1:0];
        mpeq_pkg::CFG_PER_ROUND:     per_round  <= cfg_data[mpeq_pkg::EPR_W-1:0];
      endcase
    end
  end

  // priority remap at capture
  logic [PW-1:0] req_prio;
  always_comb begin
    if (32'(priority_req) < NUM_PRIORITIES) begin
      req_prio = PW'(priority_req);
    end else if (32'(fallback) < NUM_PRIORITIES) begin
      req_prio = PW'(fallback);
    end else begin
      req_prio = PW'(NUM_PRIORITIES - 1);
    end
  end

  // captured request
  logic                            in_cmd;
  logic [PW-1:0]                   in_prio;
  logic [mpeq_pkg::ID_W-1:0]       in_id;
  logic [mpeq_pkg::SIZE_W-1:0]     in_size;
  logic [mpeq_pkg::DATA_W-1:0]     in_data;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_cmd  <= cmd_in;
      in_prio <= req_prio;
      in_id   <= type_id;
      in_size <= event_size;
      in_data <= payload;
    end
  end

  // ring state
  logic [PTRW-1:0]  wptr [NUM_PRIORITIES];
  logic [PTRW-1:0]  rptr [NUM_PRIORITIES];
  logic [DROPW-1:0] drops [NUM_PRIORITIES];
  logic             halted;
  logic             round_active;
  logic [PW-1:0]    cur_p;
  logic [KW-1:0]    k;

  logic [PTRW-1:0] occ_all [NUM_PRIORITIES];
  always_comb begin
    for (int q = 0; q < NUM_PRIORITIES; q++) begin
      if (wptr[q] >= rptr[q]) begin
        occ_all[q] = wptr[q] - rptr[q];
      end else begin
        occ_all[q] = PTRW'((PTRW+1)'(wptr[q]) + (PTRW+1)'(QUEUE_DEPTH)
                           - (PTRW+1)'(rptr[q]));
      end
    end
  end

  // one selected priority: the round cursor, else the request's
  logic [PW-1:0]    sel_p;
  logic [PTRW-1:0]  occ_sel;
  logic [PTRW-1:0]  wptr_sel;
  logic [PTRW-1:0]  rptr_sel;
  logic [DROPW-1:0] drop_sel;

  assign sel_p    = round_active ? cur_p : in_prio;
  assign occ_sel  = occ_all[sel_p];
  assign wptr_sel = wptr[sel_p];
  assign rptr_sel = rptr[sel_p];
  assign drop_sel = drops[sel_p];

  // push outcome
  logic bad;
  logic full;
  logic do_write;
  logic do_drop;
  logic do_skip;
  logic set_halt;
  logic [mpeq_pkg::STATUS_W-1:0] single_st;
  logic [PTRW-1:0]  single_depth;
  logic [DROPW-1:0] single_drop;

  assign bad  = (in_size == '0) || (32'(in_size) > PAYLOAD_BYTES)
             || ({1'b0, in_id} >= type_limit);
  assign full = (ptr_inc(wptr_sel) == rptr_sel);

  always_comb begin
    do_write  = 1'b0;
    do_drop   = 1'b0;
    do_skip   = 1'b0;
    set_halt  = 1'b0;
    single_st = mpeq_pkg::ST_QUEUED;
    if (halted || in_cmd == mpeq_pkg::CMD_ROUND) begin
      single_st = mpeq_pkg::ST_HALTED;
    end else if (bad) begin
      single_st = mpeq_pkg::ST_INVALID;
    end else if (full) begin
      if (mode == mpeq_pkg::MODE_HALT) begin
        set_halt  = 1'b1;
        single_st = mpeq_pkg::ST_HALTED;
      end else if (mode == mpeq_pkg::MODE_DROP_OLDEST) begin
        do_drop  = 1'b1;
        do_skip  = 1'b1;
        do_write = 1'b1;
      end else begin
        do_drop   = 1'b1;
        single_st = mpeq_pkg::ST_DROPPED;
      end
    end else begin
      do_write = 1'b1;
    end
  end

  assign single_depth = (do_write && !do_skip) ? occ_sel + PTRW'(1) : occ_sel;
  assign single_drop  = drop_sel + DROPW'(do_drop);

  // masked entry for the store
  entry_t wr_entry;
  always_comb begin
    wr_entry.id   = in_id;
    wr_entry.size = OSW'(in_size);
    for (int b = 0; b < PAYLOAD_BYTES; b++) begin
      wr_entry.data[b*8 +: 8] = (b < 32'(in_size)) ? in_data[b*8 +: 8] : 8'h00;
    end
  end

  // round bookkeeping
  logic [KW-1:0] lim;
  logic          later;
  logic          issue_last_c;

  always_comb begin
    if (per_round == '0) begin
      lim = KW'(1);
    end else if (32'(per_round) > MAX_PER_ROUND) begin
      lim = KW'(MAX_PER_ROUND);
    end else begin
      lim = KW'(per_round);
    end
  end

  always_comb begin
    later = 1'b0;
    for (int q = 0; q < NUM_PRIORITIES; q++) begin
      if (q > int'(cur_p) && occ_all[q] != '0) later = 1'b1;
    end
  end

  assign issue_last_c = !((((k + KW'(1)) < lim) && (occ_sel != PTRW'(1))) || later);

  // event store
  entry_t mem [MEM_SIZE];
  entry_t rd_entry;

  always_ff @(posedge clk) begin
    if (cmd.exec_single && do_write) mem[{in_prio, wptr_sel}] <= wr_entry;
    if (cmd.issue) rd_entry <= mem[{cur_p, rptr_sel}];
  end

  // metadata of the event in flight
  logic [PW-1:0]    meta_p;
  logic             meta_last;
  logic [PTRW-1:0]  meta_depth;
  logic [DROPW-1:0] meta_drop;

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      meta_p     <= cur_p;
      meta_last  <= issue_last_c;
      meta_depth <= occ_sel - PTRW'(1);
      meta_drop  <= drop_sel;
    end
  end

  // pointers, counters, control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < NUM_PRIORITIES; q++) begin
        wptr[q]  <= '0;
        rptr[q]  <= '0;
        drops[q] <= '0;
      end
      halted       <= 1'b0;
      round_active <= 1'b0;
      cur_p        <= '0;
      k            <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.exec_single) begin
        if (do_write) wptr[in_prio] <= ptr_inc(wptr_sel);
        if (do_skip)  rptr[in_prio] <= ptr_inc(rptr_sel);
        if (do_drop)  drops[in_prio] <= single_drop;
        if (set_halt) halted <= 1'b1;
      end
      if (cmd.round_start) begin
        round_active <= 1'b1;
        cur_p        <= '0;
        k            <= '0;
      end
      if (cmd.issue) begin
        rptr[cur_p] <= ptr_inc(rptr_sel);
        k           <= k + KW'(1);
      end
      if (cmd.next_prio) begin
        cur_p <= cur_p + PW'(1);
        k     <= '0;
      end
      if (cmd.round_end || (cmd.emit_event && meta_last)) round_active <= 1'b0;
      if (cmd.exec_single || cmd.emit_event || cmd.emit_empty) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec_single) begin
      status       <= single_st;
      out_priority <= OPW'(in_prio);
      out_id       <= '0;
      out_len      <= '0;
      out_payload  <= '0;
      last         <= 1'b1;
      depth        <= DEPW'(single_depth);
      drop_count   <= single_drop;
    end else if (cmd.emit_event) begin
      status       <= mpeq_pkg::ST_EVENT;
      out_priority <= OPW'(meta_p);
      out_id       <= rd_entry.id;
      out_len      <= rd_entry.size;
      out_payload  <= DW'(rd_entry.data);
      last         <= meta_last;
      depth        <= DEPW'(meta_depth);
      drop_count   <= meta_drop;
    end else if (cmd.emit_empty) begin
      status       <= mpeq_pkg::ST_EMPTY;
      out_priority <= OPW'(in_prio);
      out_id       <= '0;
      out_len      <= '0;
      out_payload  <= '0;
      last         <= 1'b1;
      depth        <= DEPW'(occ_sel);
      drop_count   <= drop_sel;
    end
  end

  assign sts.is_round   = (in_cmd == mpeq_pkg::CMD_ROUND);
  assign sts.halted     = halted;
  assign sts.out_free   = !out_valid || !out_stall;
  assign sts.can_pop    = round_active && (occ_sel != '0) && (k < lim);
  assign sts.prio_final = (cur_p == PW'(NUM_PRIORITIES - 1));
  assign sts.issue_last = meta_last;

endmodule
`default_nettype wire

@@ sv/multi_priority_event_queue_top.sv @@
// Top level of the multi-priority event queue (strict-priority ring queues).
//
// Requests come in on in_valid/in_stall with cmd, priority_req, type_id,
// event_size and payload. cmd 0 pushes one event into the ring of its
// priority; cmd 1 runs a drain round from priority 0 downward, at most
// events_per_round events per priority. Results leave on out_valid/out_stall;
// last marks the final result of a request. Configuration is a plain write
// port (cfg_write, cfg_index, cfg_data); the user must write it only while the
// block is idle, as the block itself does not enforce this. A push, an invalid
// request or a halted reply goes from acceptance to the execute state and is
// loaded into the output register from there once the output is free; the next request is taken only after that.
// A round moves past each priority that is empty or has used its share, and
// takes a store read, then a result load, per event, set by the single read
// port of the event store; an empty round walks every priority, then answers.
// One request is worked at a time; in_stall is high until its last result is
// in the output register, which may still be waiting on out_stall.
// out_stall holds the result register and pauses the round; nothing is lost.
// Reset empties every ring, clears drop counters and the halt flag and loads
// the config defaults; the event store itself is not cleared.
`default_nettype none
`include "multi_priority_event_queue_top_assert.svh"
module multi_priority_event_queue_top #(
  parameter int NUM_PRIORITIES = 4,
  parameter int QUEUE_DEPTH    = 16,
  parameter int PAYLOAD_BYTES  = 8,
  parameter int MAX_PER_ROUND  = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [mpeq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mpeq_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             cmd,
  input  wire logic [mpeq_pkg::PRIO_REQ_W-1:0]  priority_req,
  input  wire logic [mpeq_pkg::ID_W-1:0]        type_id,
  input  wire logic [mpeq_pkg::SIZE_W-1:0]      event_size,
  input  wire logic [mpeq_pkg::DATA_W-1:0]      payload,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [mpeq_pkg::STATUS_W-1:0]         status,
  output logic [mpeq_pkg::OUT_PRIO_W-1:0]       out_priority,
  output logic [mpeq_pkg::ID_W-1:0]             out_id,
  output logic [mpeq_pkg::OUT_SIZE_W-1:0]       out_len,
  output logic [mpeq_pkg::DATA_W-1:0]           out_payload,
  output logic                                  last,
  output logic [mpeq_pkg::DEPTH_W-1:0]          depth,
  output logic [mpeq_pkg::DROP_W-1:0]           drop_count
);

  mpeq_pkg::ctrl_cmd_t ctl_cmd;
  mpeq_pkg::ctrl_sts_t ctl_sts;

  // sequencing
  mpeq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (ctl_sts),
    .cmd      (ctl_cmd)
  );

  // rings, store and result register
  mpeq_dp #(
    .NUM_PRIORITIES (NUM_PRIORITIES),
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .PAYLOAD_BYTES  (PAYLOAD_BYTES),
    .MAX_PER_ROUND  (MAX_PER_ROUND)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd_in       (cmd),
    .priority_req (priority_req),
    .type_id      (type_id),
    .event_size   (event_size),
    .payload      (payload),
    .cmd          (ctl_cmd),
    .sts          (ctl_sts),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .out_priority (out_priority),
    .out_id       (out_id),
    .out_len      (out_len),
    .out_payload  (out_payload),
    .last         (last),
    .depth        (depth),
    .drop_count   (drop_count)
  );

  // a request is worked alone: the input closes right after acceptance
  `MPEQ_ASSERT_NEXT(a_one_request, clk, rst, in_valid && !in_stall, in_stall)
  // anything but an emitted event is the only result of its request
  `MPEQ_ASSERT_IMPLY(a_single_last, clk, rst, out_valid && status != mpeq_pkg::ST_EVENT, last)
  // emitted events only come from valid pushes
  `MPEQ_ASSERT_IMPLY(a_event_size, clk, rst, out_valid && status == mpeq_pkg::ST_EVENT, out_len != 4'd0 && 32'(out_len) <= PAYLOAD_BYTES)
  // the controller issues at most one command per cycle
  `MPEQ_ASSERT_IMPLY(a_one_cmd, clk, rst, ctl_cmd != '0, $onehot(ctl_cmd))

endmodule
`default_nettype wire
